>>> hw/rtl/srec_image_loader_parser_macros.svh
// Assertion macros for the S-record image loader parser.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef SREC_IMAGE_LOADER_PARSER_MACROS_SVH
`define SREC_IMAGE_LOADER_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SILP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SILP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/silp_pkg.sv
// Shared types, codes and the hex digit decode for the S-record parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package silp_pkg;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_BELOW  = 2'd2,
        KIND_BADCNT = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] addr;
        logic [31:0] data;
    } t_result;

    typedef struct packed {
        logic halted;
        logic busy;
    } t_stat;

    localparam logic [7:0]  CH_S       = 8'h53;
    localparam logic [7:0]  CH_0       = 8'h30;
    localparam logic [7:0]  CH_3       = 8'h33;
    localparam logic [7:0]  CH_7       = 8'h37;
    localparam logic [7:0]  CH_9       = 8'h39;
    localparam logic [7:0]  CH_NL      = 8'h0A;
    localparam logic [7:0]  CH_UA      = 8'h41;
    localparam logic [7:0]  CH_UZ      = 8'h5A;
    localparam logic [7:0]  CH_LA      = 8'h61;
    localparam logic [7:0]  CH_LZ      = 8'h7A;
    localparam logic [7:0]  MIN_COUNT  = 8'd5;
    localparam logic [31:0] BASE_RESET = 32'h4000_0000;

    // Digits give 0-9, letters of either case give (upper - 'A' + 10) mod 16,
    // anything else gives 0.
    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [7:0] u;
        logic [7:0] t;
        u = ((c >= CH_LA) && (c <= CH_LZ)) ? (c - 8'd32) : c;
        t = u - CH_UA + 8'd10;
        if ((c >= CH_0) && (c <= CH_9)) begin
            digit_value = c[3:0];
        end else if ((u >= CH_UA) && (u <= CH_UZ)) begin
            digit_value = t[3:0];
        end else begin
            digit_value = 4'd0;
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/silp_core.sv
// Parse state machine: decodes one character per step into records and results.
// Depends on silp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module silp_core
    import silp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic [7:0]  i_char,
    input  wire logic [31:0] i_region_base,
    output logic             o_res_valid,
    output t_result          o_res,
    output t_stat            o_stat
);

    typedef enum logic [3:0] {
        PH_START, PH_TYPE, PH_SKIP, PH_COUNT, PH_ADDR, PH_DATA
    } t_phase;

    localparam logic [1:0] RT_NONE = 2'd0;
    localparam logic [1:0] RT_S3   = 2'd1;
    localparam logic [1:0] RT_S7   = 2'd2;

    t_phase      r_phase,  n_phase;
    logic [1:0]  r_rtype,  n_rtype;
    logic [3:0]  r_hi,     n_hi;
    logic        r_second, n_second;
    logic [7:0]  r_left,   n_left;
    logic [31:0] r_accum,  n_accum;
    logic [2:0]  r_fill,   n_fill;
    logic [31:0] r_load,   n_load;
    logic        r_halted, n_halted;

    logic [3:0]  dv;
    logic [7:0]  b;
    logic [31:0] la;
    logic [31:0] pa;
    logic [31:0] acc;
    logic [2:0]  f;
    logic [7:0]  left_dec;

    always_comb begin
        dv       = digit_value(i_char);
        b        = {r_hi, dv};
        la       = {r_load[23:0], b};
        pa       = {2'b01, la[29:0]};
        acc      = {r_accum[23:0], b};
        f        = r_fill + 3'd1;
        left_dec = r_left - 8'd1;

        n_phase  = r_phase;
        n_rtype  = r_rtype;
        n_hi     = r_hi;
        n_second = r_second;
        n_left   = r_left;
        n_accum  = r_accum;
        n_fill   = r_fill;
        n_load   = r_load;
        n_halted = r_halted;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_step && !r_halted) begin
            case (r_phase)
                PH_START: begin
                    if (i_char == CH_S) begin
                        n_phase = PH_TYPE;
                    end else begin
                        n_halted    = 1'b1;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_DONE;
                    end
                end
                PH_TYPE: begin
                    n_second = 1'b0;
                    n_fill   = 3'd0;
                    n_load   = 32'd0;
                    if (i_char == CH_0) begin
                        n_phase = PH_SKIP;
                    end else if ((i_char == CH_3) || (i_char == CH_7)) begin
                        n_rtype = (i_char == CH_3) ? RT_S3 : RT_S7;
                        n_phase = PH_COUNT;
                    end else begin
                        n_halted    = 1'b1;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_DONE;
                    end
                end
                PH_SKIP: begin
                    if (i_char == CH_NL) begin
                        n_phase = PH_START;
                    end
                end
                PH_COUNT, PH_ADDR, PH_DATA: begin
                    if (!r_second) begin
                        n_hi     = dv;
                        n_second = 1'b1;
                    end else begin
                        n_second = 1'b0;
                        if (r_phase == PH_COUNT) begin
                            if (b < MIN_COUNT) begin
                                n_halted    = 1'b1;
                                o_res_valid = 1'b1;
                                o_res.kind  = KIND_BADCNT;
                            end else begin
                                n_left  = b - MIN_COUNT;
                                n_fill  = 3'd0;
                                n_load  = 32'd0;
                                n_phase = PH_ADDR;
                            end
                        end else if (r_phase == PH_ADDR) begin
                            if (!f[2]) begin
                                n_load = la;
                                n_fill = f;
                            end else begin
                                n_fill = 3'd0;
                                if (r_rtype != RT_S3) begin
                                    // start address is reported as read
                                    n_halted    = 1'b1;
                                    o_res_valid = 1'b1;
                                    o_res.kind  = KIND_DONE;
                                    o_res.addr  = la;
                                end else if (pa < i_region_base) begin
                                    n_halted    = 1'b1;
                                    o_res_valid = 1'b1;
                                    o_res.kind  = KIND_BELOW;
                                    o_res.addr  = pa;
                                end else begin
                                    n_load  = pa;
                                    n_accum = 32'd0;
                                    n_phase = (r_left == 8'd0) ? PH_SKIP : PH_DATA;
                                end
                            end
                        end else begin
                            n_left = left_dec;
                            if (f[2] || (left_dec == 8'd0)) begin
                                o_res_valid = 1'b1;
                                o_res.kind  = KIND_DATA;
                                o_res.addr  = r_load;
                                // zero pad a short last word in its low bytes
                                case (f)
                                    3'd1:    o_res.data = {acc[7:0], 24'd0};
                                    3'd2:    o_res.data = {acc[15:0], 16'd0};
                                    3'd3:    o_res.data = {acc[23:0], 8'd0};
                                    default: o_res.data = acc;
                                endcase
                                n_load  = r_load + 32'd4;
                                n_accum = 32'd0;
                                n_fill  = 3'd0;
                                if (left_dec == 8'd0) begin
                                    n_phase = PH_SKIP;
                                end
                            end else begin
                                n_accum = acc;
                                n_fill  = f;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_START;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_rtype  <= RT_NONE;
            r_hi     <= 4'd0;
            r_second <= 1'b0;
            r_left   <= 8'd0;
            r_accum  <= 32'd0;
            r_fill   <= 3'd0;
            r_load   <= 32'd0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_rtype  <= n_rtype;
            r_hi     <= n_hi;
            r_second <= n_second;
            r_left   <= n_left;
            r_accum  <= n_accum;
            r_fill   <= n_fill;
            r_load   <= n_load;
            r_halted <= n_halted;
        end
    end

    assign o_stat.halted = r_halted;
    assign o_stat.busy   = (r_phase != PH_START);

endmodule

`default_nettype wire

>>> hw/rtl/silp_out_reg.sv
// Result register in front of the master stream port.
// Depends on silp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module silp_out_reg
    import silp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_result     i_res,
    output logic             o_free,
    output logic             o_tvalid,
    input  wire logic        i_tready,
    output logic [63:0]      o_tdata,
    output logic [1:0]       o_tuser
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {r_res.data, r_res.addr};
    assign o_tuser  = r_res.kind;

endmodule

`default_nettype wire

>>> hw/rtl/srec_image_loader_parser.sv
// Top level of the S-record image loader parser: input register, parse core,
// result register and region base register. Depends on silp_pkg, silp_core,
// silp_out_reg and srec_image_loader_parser_macros.svh.
//
// Usage:
//   s_axis carries the image text, one ASCII character per item in tdata.
//   m_axis carries results: tuser is the kind (data word, finished with start
//   address, address below region, malformed count), tdata holds the word
//   address in bits 31:0 and the data word in bits 63:32.
//   The cfg channel writes region_base, the lowest legal physical load
//   address; write it only while no character is in flight.
// Path: an accepted character sits in the input register; its result, if any, is
//   registered in the result register and shown on m_axis from there.
// Throughput: one character per cycle unless m_axis stalls. Most characters
//   give no result; the input register drains straight into the parse core
//   whenever the result register is free.
// Stall: when m_axis_tready is low with a result pending, the input register
//   holds one more character and s_axis_tready drops until the result is taken.
// Reset: synchronous, active low. Clears the parser to expect a record start,
//   drops both registers and sets region_base to 0x4000_0000. After a finish
//   or error result the parser halts and swallows all further characters
//   until the next reset; cfg writes are still taken.
`timescale 1ns / 1ps
`default_nettype none

`include "srec_image_loader_parser_macros.svh"

module srec_image_loader_parser
    import silp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // text input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_char
    // result output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [31:0] word_address, [63:32] data_word
    output logic [1:0]       m_axis_tuser,   // [1:0] result_kind
    // region base write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic [31:0] r_region_base;

    logic        out_free;
    logic        step;
    logic        res_valid;
    t_result     res;
    t_stat       stat;

    // Advance the held character into the core only when its result can land.
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_region_base <= BASE_RESET;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_region_base <= i_cfg_data;
            end
        end
    end

    // Payload: hold the character until it is consumed.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
        end
    end

    silp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_char        (r_in_char),
        .i_region_base (r_region_base),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .o_stat        (stat)
    );

    silp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (step && res_valid),
        .i_res    (res),
        .o_free   (out_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

    // Halt is sticky until reset.
    `SILP_ASSERT_NXT(a_halt_sticky, stat.halted, stat.halted, "parser left halt without reset")
    // Any non-data result halts the parser.
    `SILP_ASSERT_NXT(a_end_halts, step && res_valid && (res.kind != KIND_DATA), stat.halted, "end result without halt")
    // A halted parser produces nothing.
    `SILP_ASSERT_IMP(a_halt_quiet, stat.halted, !res_valid, "result produced while halted")
    // Input back-pressure only with a character held.
    `SILP_ASSERT_IMP(a_stall_held, !s_axis_tready, r_in_valid && !out_free, "input stalled while empty")

endmodule

`default_nettype wire

>>> bench/srec_image_loader_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for srec_image_loader_parser: streams S-record text,
// predicts each result item and compares it with what m_axis delivers.
// Depends on silp_pkg and the srec_image_loader_parser RTL only.

module srec_image_loader_parser_tb;
    import silp_pkg::*;

    localparam int PHASE_CHARS   = 280;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;

    localparam int DATA_RANDOM = 0;
    localparam int DATA_ONES   = 1;
    localparam int DATA_ZEROS  = 2;
    localparam int DATA_NOISY  = 3;

    typedef enum int {P_START, P_TYPE, P_SKIP, P_COUNT, P_ADDR, P_DATA} t_parse_phase;
    typedef enum int {REC_NONE, REC_S3, REC_S7} t_rec_type;
    typedef enum int {END_S7, END_NOT_S, END_BAD_TYPE, END_SHORT_COUNT, END_BELOW} t_end_case;

    // Tracks the parser state from accepted characters and holds the results
    // still owed by the block, oldest first.
    class t_srec_tracker;
        logic [31:0]  base;
        t_parse_phase phase;
        t_rec_type    rec;
        logic [3:0]   hi;
        logic         second;
        logic [7:0]   left;
        logic [31:0]  accum;
        int           fill;
        logic [31:0]  load_addr;
        logic         halted;
        t_result      awaited[$];
        int           fail_count;

        function new();
            base       = BASE_RESET;
            phase      = P_START;
            rec        = REC_NONE;
            hi         = 4'd0;
            second     = 1'b0;
            left       = 8'd0;
            accum      = 32'd0;
            fill       = 0;
            load_addr  = 32'd0;
            halted     = 1'b0;
            fail_count = 0;
        endfunction

        function logic [3:0] nibble_of(logic [7:0] c);
            logic [7:0] up;
            logic [7:0] sum;
            up  = (c >= CH_LA && c <= CH_LZ) ? c - 8'd32 : c;
            sum = up - CH_UA + 8'd10;
            if (c >= CH_0 && c <= CH_9) begin
                return c[3:0];
            end
            if (up >= CH_UA && up <= CH_UZ) begin
                return sum[3:0];
            end
            return 4'd0;
        endfunction

        function void stop(t_kind kind, logic [31:0] addr);
            halted = 1'b1;
            awaited.push_back('{kind: kind, addr: addr, data: 32'd0});
        endfunction

        // Advance the parser by one accepted character.
        function void parse_char(logic [7:0] c);
            logic [7:0]  b;
            logic [31:0] word;
            if (halted) return;
            case (phase)
                P_START: begin
                    if (c == CH_S) phase = P_TYPE;
                    else stop(KIND_DONE, 32'd0);
                end
                P_TYPE: begin
                    second    = 1'b0;
                    fill      = 0;
                    load_addr = 32'd0;
                    if (c == CH_0) begin
                        phase = P_SKIP;
                    end else if (c == CH_3 || c == CH_7) begin
                        rec   = (c == CH_3) ? REC_S3 : REC_S7;
                        phase = P_COUNT;
                    end else begin
                        stop(KIND_DONE, 32'd0);
                    end
                end
                P_SKIP: begin
                    if (c == CH_NL) phase = P_START;
                end
                default: begin
                    if (!second) begin
                        hi     = nibble_of(c);
                        second = 1'b1;
                        return;
                    end
                    second = 1'b0;
                    b      = {hi, nibble_of(c)};
                    if (phase == P_COUNT) begin
                        if (b < MIN_COUNT) begin
                            stop(KIND_BADCNT, 32'd0);
                        end else begin
                            left      = b - MIN_COUNT;
                            fill      = 0;
                            load_addr = 32'd0;
                            phase     = P_ADDR;
                        end
                    end else if (phase == P_ADDR) begin
                        load_addr = {load_addr[23:0], b};
                        fill++;
                        if (fill == 4) begin
                            fill = 0;
                            if (rec != REC_S3) begin
                                stop(KIND_DONE, load_addr);
                            end else begin
                                // clear bits 31:30, then set bit 30
                                load_addr = {2'b01, load_addr[29:0]};
                                if (load_addr < base) begin
                                    stop(KIND_BELOW, load_addr);
                                end else begin
                                    accum = 32'd0;
                                    phase = (left == 8'd0) ? P_SKIP : P_DATA;
                                end
                            end
                        end
                    end else begin
                        accum = {accum[23:0], b};
                        fill++;
                        left = left - 8'd1;
                        if (fill == 4 || left == 8'd0) begin
                            word = accum << (8 * (4 - fill));
                            awaited.push_back('{kind: KIND_DATA, addr: load_addr, data: word});
                            load_addr += 32'd4;
                            accum = 32'd0;
                            fill  = 0;
                            if (left == 8'd0) phase = P_SKIP;
                        end
                    end
                end
            endcase
        endfunction

        function void match_result(t_kind kind, logic [31:0] addr, logic [31:0] data);
            t_result want;
            if (awaited.size() == 0) begin
                $display("%0t: result with none expected: kind %0d addr %h data %h",
                         $time, kind, addr, data);
                fail_count++;
                return;
            end
            want = awaited.pop_front();
            if (kind !== want.kind) begin
                $display("%0t: kind mismatch: expected %0d actual %0d", $time, want.kind, kind);
                fail_count++;
            end
            if (addr !== want.addr) begin
                $display("%0t: address mismatch: expected %h actual %h", $time, want.addr, addr);
                fail_count++;
            end
            if (data !== want.data) begin
                $display("%0t: data mismatch: expected %h actual %h", $time, want.data, data);
                fail_count++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;     // [7:0] text_char
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;            // [31:0] word_address, [63:32] data_word
    logic [1:0]  m_axis_tuser;            // [1:0] result_kind
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = 32'd0;

    t_srec_tracker tracker = new();
    int            src_idle_pct = 0;
    int            rx_idle_pct = 0;
    int            chars_sent = 0;
    int            cycles = 0;

    srec_image_loader_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Receiver side: stall at random at the current rate.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.match_result(t_kind'(m_axis_tuser), m_axis_tdata[31:0],
                                 m_axis_tdata[63:32]);
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("srec_image_loader_parser verification failed");
        $finish;
    end

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 4'd10) return CH_0 + 8'(v);
        return (lower ? CH_LA : CH_UA) + 8'(v) - 8'd10;
    endfunction

    // Any byte but newline, for header text and trailing junk.
    function automatic logic [7:0] text_noise();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        return (c == CH_NL) ? 8'hFF : c;
    endfunction

    // Offer one character; idle first at the sender rate, keep valid high
    // across back-to-back items.
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        chars_sent++;
        tracker.parse_char(c);
    endtask

    task automatic send_hex(input logic [7:0] b);
        bit lower;
        lower = ($urandom_range(0, 3) == 0);
        send_char(hex_char(b[7:4], lower));
        send_char(hex_char(b[3:0], lower));
    endtask

    task automatic send_s0(input int len);
        send_char(CH_S);
        send_char(CH_0);
        repeat (len) send_char(text_noise());
        send_char(CH_NL);
    endtask

    // S3 line with n data bytes; count_adj skews the count byte away from
    // the real length to make a broken record.
    task automatic send_s3(input logic [31:0] raw, input int n, input int count_adj,
                           input int data_mode);
        logic [7:0] d;
        send_char(CH_S);
        send_char(CH_3);
        send_hex(8'(n + 5 + count_adj));
        for (int i = 3; i >= 0; i--) send_hex(raw[8*i +: 8]);
        for (int i = 0; i < n; i++) begin
            case (data_mode)
                DATA_ONES:  d = 8'hFF;
                DATA_ZEROS: d = 8'h00;
                default:    d = 8'($urandom_range(0, 255));
            endcase
            if (data_mode == DATA_NOISY) begin
                // every character inside a record counts as a digit
                send_char(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                      : hex_char(d[7:4], 1'b0));
                send_char(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                      : hex_char(d[3:0], 1'b1));
            end else begin
                send_hex(d);
            end
        end
        send_hex(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) send_char(text_noise());
        send_char(CH_NL);
    endtask

    // Bring the parser back to a line start after a record with a long count.
    task automatic resync();
        while (!tracker.halted && tracker.phase != P_START) begin
            send_char((tracker.phase == P_SKIP) ? CH_NL : CH_0);
        end
    endtask

    // Hold the sender until every owed result is out, then let the
    // input register settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.awaited.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [31:0] v);
        resync();
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.base = v;
    endtask

    task automatic run_phase(input int src_pct, input int rx_pct, input logic [31:0] base,
                             input bit stress);
        int          first;
        int          pick;
        int          n;
        bit          paused;
        logic [31:0] floor_addr;
        logic [31:0] phys;
        write_base(base);
        src_idle_pct = src_pct;
        rx_idle_pct  = rx_pct;
        first        = chars_sent;
        paused       = 1'b0;
        floor_addr   = (base < BASE_RESET) ? BASE_RESET : base;
        if (stress) begin
            // long record at a legal address, high address bits set
            phys = $urandom_range(32'h7FFF_FFFF, floor_addr);
            send_s3({2'b11, phys[29:0]}, 250, 0, DATA_RANDOM);
        end
        while (chars_sent - first < PHASE_CHARS && !tracker.halted) begin
            if (stress && !paused && chars_sent - first >= PHASE_CHARS / 2) begin
                drain();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 19);
            n    = (pick < 16) ? $urandom_range(0, 16)
                 : (pick < 19) ? $urandom_range(17, 60) : $urandom_range(61, 120);
            phys = $urandom_range(32'h7FFF_FFFF, floor_addr);
            case ($urandom_range(0, 9))
                0: send_s0($urandom_range(0, 12));
                // long count swallows part of the next line
                1: send_s3({2'($urandom), phys[29:0]}, n, $urandom_range(1, 8), DATA_RANDOM);
                2: send_s3({2'($urandom), phys[29:0]}, n,
                           (n == 0) ? 0 : -$urandom_range(1, n), DATA_RANDOM);
                3: send_s3({2'($urandom), phys[29:0]}, n, 0, DATA_NOISY);
                default: send_s3({2'($urandom), phys[29:0]}, n, 0, DATA_RANDOM);
            endcase
        end
    endtask

    // Pick one way to stop the parser; every address is below an all-ones base.
    task automatic finish_image();
        t_end_case  how;
        logic [7:0] c;
        write_base(32'hFFFF_FFFF);
        how = t_end_case'($urandom_range(0, 4));
        case (how)
            END_S7: begin
                send_char(CH_S);
                send_char(CH_7);
                send_hex(MIN_COUNT);
                repeat (4) send_hex(8'($urandom_range(0, 255)));
                send_hex(8'($urandom_range(0, 255)));
                send_char(CH_NL);
            end
            END_NOT_S: begin
                c = 8'($urandom_range(0, 255));
                send_char((c == CH_S) ? 8'h00 : c);
            end
            END_BAD_TYPE: begin
                do c = 8'($urandom_range(0, 255)); while (c == CH_0 || c == CH_3 || c == CH_7);
                send_char(CH_S);
                send_char(c);
            end
            END_SHORT_COUNT: begin
                send_char(CH_S);
                send_char(($urandom_range(0, 1) == 0) ? CH_3 : CH_7);
                send_hex(8'($urandom_range(0, 4)));
            end
            default: send_s3(32'($urandom), $urandom_range(0, 8), 0, DATA_RANDOM);
        endcase
        // parser is halted now: these must be swallowed without a result
        repeat (6) send_char(8'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: header text with extreme bytes, then S3 records at the
        // reset base covering empty, full and partial words, wrapping high
        // address bits, lowercase hex and junk digits.
        src_idle_pct = 36;
        rx_idle_pct  = 64;
        send_char(CH_S);
        send_char(CH_0);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h80);
        send_char(CH_NL);
        send_s3(32'h0000_0000, 0, 0, DATA_RANDOM);
        send_s3(32'hFFFF_FFFC, 4, 0, DATA_ONES);
        send_s3(32'hC000_1000, 5, 0, DATA_RANDOM);
        send_s3(32'h8000_0002, 6, 0, DATA_ZEROS);
        send_s3(32'h0123_4567, 7, 0, DATA_NOISY);
        send_s3(32'h7FFF_FFF0, 3, 2, DATA_RANDOM);
        send_s3(32'h3FFF_FFFF, 9, 0, DATA_RANDOM);

        run_phase(36, 64, 32'h0000_0000, 1'b0);
        run_phase(64, 36, $urandom_range(32'h7FFF_FFFF, 32'h4000_0000), 1'b0);
        run_phase(0, 0, BASE_RESET + 32'($urandom_range(0, 32'h0FFF_FFFF)), 1'b1);
        finish_image();
        drain();

        if (tracker.fail_count == 0) begin
            $display("srec_image_loader_parser verification clean");
        end else begin
            $display("srec_image_loader_parser verification failed");
        end
        $finish;
    end

endmodule
